>>> hw/rtl/tsba_pkg.sv
// ----------------------------------------------------------------------------
// tsba_pkg
// shared types and shape tables for the tile sheet buddy allocator
// ----------------------------------------------------------------------------
`default_nettype none

package tsba_pkg;

    localparam int NSHAPES = 12;
    localparam logic [3:0] BIGGEST = 4'd11;
    localparam logic [3:0] NONE    = 4'd15;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    typedef struct packed {
        logic       op;
        logic [3:0] req_width;
        logic [3:0] req_height;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] block_x;
        logic [4:0] block_y;
        logic [9:0] tile_offset;
    } t_rsp;

    function automatic logic [1:0] shape_lw(input logic [3:0] s);
        case (s)
            4'd0, 4'd1, 4'd2:             shape_lw = 2'd0;
            4'd3, 4'd4, 4'd5:             shape_lw = 2'd1;
            4'd6, 4'd7, 4'd8, 4'd9:       shape_lw = 2'd2;
            default:                      shape_lw = 2'd3;
        endcase
    endfunction

    function automatic logic [1:0] shape_lh(input logic [3:0] s);
        case (s)
            4'd0, 4'd3, 4'd6:             shape_lh = 2'd0;
            4'd1, 4'd4, 4'd7:             shape_lh = 2'd1;
            4'd2, 4'd5, 4'd8, 4'd10:      shape_lh = 2'd2;
            default:                      shape_lh = 2'd3;
        endcase
    endfunction

    // log2 of a side, bit 2 set when the side is unsupported
    function automatic logic [2:0] side_log(input logic [3:0] v);
        case (v)
            4'd1:    side_log = 3'd0;
            4'd2:    side_log = 3'd1;
            4'd4:    side_log = 3'd2;
            4'd8:    side_log = 3'd3;
            default: side_log = 3'd4;
        endcase
    endfunction

    function automatic logic [3:0] shape_index(input logic [1:0] lw, input logic [1:0] lh);
        logic [3:0] r;
        r = NONE;
        case (lw)
            2'd0: r = (lh == 2'd3) ? NONE : {2'b00, lh};
            2'd1: r = (lh == 2'd3) ? NONE : 4'd3 + {2'b00, lh};
            2'd2: r = 4'd6 + {2'b00, lh};
            2'd3: r = (lh == 2'd2) ? 4'd10 : (lh == 2'd3) ? 4'd11 : NONE;
            default: r = NONE;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] grow_n(input logic [3:0] s);
        case (s)
            4'd0, 4'd1, 4'd3, 4'd4, 4'd8: grow_n = 2'd2;
            4'd11:                        grow_n = 2'd0;
            default:                      grow_n = 2'd1;
        endcase
    endfunction

    function automatic logic [3:0] grow0(input logic [3:0] s);
        case (s)
            4'd0:  grow0 = 4'd3;
            4'd1:  grow0 = 4'd2;
            4'd2:  grow0 = 4'd5;
            4'd3:  grow0 = 4'd6;
            4'd4:  grow0 = 4'd7;
            4'd5:  grow0 = 4'd8;
            4'd6:  grow0 = 4'd7;
            4'd7:  grow0 = 4'd8;
            4'd8:  grow0 = 4'd10;
            4'd9:  grow0 = 4'd11;
            4'd10: grow0 = 4'd11;
            default: grow0 = NONE;
        endcase
    endfunction

    function automatic logic [3:0] grow1(input logic [3:0] s);
        case (s)
            4'd0:  grow1 = 4'd1;
            4'd1:  grow1 = 4'd4;
            4'd3:  grow1 = 4'd4;
            4'd4:  grow1 = 4'd5;
            4'd8:  grow1 = 4'd9;
            default: grow1 = NONE;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tsba_if.sv
// ----------------------------------------------------------------------------
// tsba_if
// valid/ready channel carrying one word of type T
// ----------------------------------------------------------------------------
`default_nettype none

interface tsba_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tsba_ram.sv
// ----------------------------------------------------------------------------
// tsba_ram
// single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tsba_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

>>> hw/rtl/tile_sheet_buddy_allocator.sv
// ----------------------------------------------------------------------------
// tile_sheet_buddy_allocator
// two-dimensional buddy allocator over a sprite tile sheet
// ----------------------------------------------------------------------------
// channel | dir | word    | accepted when
// req     | in  | t_req   | req.valid & req.ready
// rsp     | out | t_rsp   | rsp.valid & rsp.ready
// cfg     | in  | 1 bit   | i_cfg_we
//
// one word at a time. a clear fills the largest list with the 8x8 blocks of
// the sheet (up to 16); an allocate searches the lists upward, pops a block
// from the free block ram and, if it came from a larger level, splits it down,
// pushing each buddy onto its list. the response register holds a finished
// word while the next request waits. reset empties all lists.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_sheet_buddy_allocator #(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_index,
    input  wire logic i_cfg_data,
    tsba_if.sink      req,
    tsba_if.source    rsp
);
    localparam int PW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int DEPTH = tsba_pkg::NSHAPES * LIST_DEPTH;
    localparam int AW = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_SPLIT  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]    r_state;
    logic          r_four_bpp;
    logic          r_bitmap;
    logic [PW-1:0] r_head [tsba_pkg::NSHAPES];
    logic [CW-1:0] r_count[tsba_pkg::NSHAPES];
    logic [3:0]    r_slice[tsba_pkg::NSHAPES];
    logic [3:0]    r_ns;
    logic [3:0]    r_cur;
    logic [4:0]    r_bx, r_by;
    logic [1:0]    r_w, r_h;
    logic [4:0]    r_cx, r_cy;
    logic          r_rsp_valid;
    tsba_pkg::t_rsp r_rsp;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [9:0]    ram_wdata, ram_rdata;

    tsba_ram #(.WIDTH(10), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    function automatic logic [AW-1:0] addr_of(input logic [3:0] l, input logic [PW-1:0] p);
        return AW'(l * LIST_DEPTH) + AW'(p);
    endfunction

    // ring position p + c, wrapped at the list depth
    function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] p, input logic [CW-1:0] c);
        logic [CW:0] s;
        s = (CW+1)'(p) + (CW+1)'(c);
        if (s >= (CW+1)'(LIST_DEPTH)) begin
            s = s - (CW+1)'(LIST_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    logic          req_fire;
    logic [2:0]    lw3, lh3;
    logic [3:0]    shp;
    logic          nonempty_cur;
    logic [3:0]    g0, g1, cand;
    logic [1:0]    gn;
    logic [3:0]    tsl;
    logic [4:0]    ox, oy;
    logic [1:0]    nw, nh;
    logic [4:0]    bx_f, by_f;
    logic [9:0]    off;
    logic [4:0]    clr_w, clr_h;

    assign req.ready = (r_state == S_IDLE) && !r_rsp_valid;
    assign req_fire  = req.valid && req.ready;
    assign rsp.valid = r_rsp_valid;
    assign rsp.data  = r_rsp;

    assign lw3 = tsba_pkg::side_log(req.data.req_width);
    assign lh3 = tsba_pkg::side_log(req.data.req_height);
    assign shp = (lw3[2] || lh3[2]) ? tsba_pkg::NONE
               : tsba_pkg::shape_index(lw3[1:0], lh3[1:0]);

    assign gn = tsba_pkg::grow_n(r_cur);
    assign g0 = tsba_pkg::grow0(r_cur);
    assign g1 = tsba_pkg::grow1(r_cur);
    always_comb begin
        cand = (gn == 2'd2) ? g1 : g0;
        if (r_count[g0] != '0) begin
            cand = g0;
        end else if (gn == 2'd2 && r_count[g1] != '0) begin
            cand = g1;
        end
    end
    assign nonempty_cur = (r_count[r_cur] != '0);

    // split geometry for the slice at the back of the chain
    assign tsl = r_slice[r_ns - 4'd1];
    always_comb begin
        nw = r_w;
        nh = r_h;
        if (tsba_pkg::shape_lw(tsl) == r_w && r_h != 2'd0) begin
            nh = r_h - 2'd1;
            ox = r_bx;
            oy = r_by + (5'd1 << nh);
        end else begin
            if (r_w != 2'd0) begin
                nw = r_w - 2'd1;
            end
            ox = r_bx + (5'd1 << nw);
            oy = r_by;
        end
    end

    assign bx_f = (r_state == S_READ) ? ram_rdata[4:0] : r_bx;
    assign by_f = (r_state == S_READ) ? ram_rdata[9:5] : r_by;
    // 8bpp: (y*16 + x)*2, x may exceed 15 after a mode change
    assign off  = r_four_bpp ? {by_f, bx_f} : ({by_f, 5'd0} + {4'd0, bx_f, 1'b0});
    assign clr_w = r_four_bpp ? 5'd24 : 5'd8;
    assign clr_h = r_bitmap ? 5'd8 : 5'd24;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_of(tsba_pkg::BIGGEST, r_count[tsba_pkg::BIGGEST][PW-1:0]);
        ram_wdata = {r_cy, r_cx};
        ram_raddr = addr_of(r_cur, r_head[r_cur]);
        if (r_state == S_CLEAR) begin
            ram_we = (r_count[tsba_pkg::BIGGEST] < CW'(LIST_DEPTH));
        end else if (r_state == S_SPLIT) begin
            ram_waddr = addr_of(tsl, ring_add(r_head[tsl], r_count[tsl]));
            ram_wdata = {oy, ox};
            ram_we    = (r_count[tsl] < CW'(LIST_DEPTH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_four_bpp  <= 1'b0;
            r_bitmap    <= 1'b0;
            r_rsp_valid <= 1'b0;
            for (int i = 0; i < tsba_pkg::NSHAPES; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == 1'b0) r_four_bpp <= i_cfg_data;
                else                     r_bitmap   <= i_cfg_data;
            end
            if (rsp.valid && rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_ns  <= 4'd1;
                        r_slice[0] <= shp;
                        r_cur <= shp;
                        if (req.data.op == tsba_pkg::OP_CLEAR) begin
                            r_rsp <= '0;
                            for (int i = 0; i < tsba_pkg::NSHAPES; i++) begin
                                r_head[i]  <= '0;
                                r_count[i] <= '0;
                            end
                            r_cx <= '0;
                            r_cy <= '0;
                            r_state <= S_CLEAR;
                        end else if (shp == tsba_pkg::NONE) begin
                            r_rsp <= '{status: tsba_pkg::ST_INVALID, default: '0};
                            r_rsp_valid  <= 1'b1;
                        end else begin
                            r_rsp <= '0;
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_CLEAR: begin
                    if (ram_we) begin
                        r_count[tsba_pkg::BIGGEST] <= r_count[tsba_pkg::BIGGEST] + 1'b1;
                    end
                    if (r_cx == clr_w) begin
                        r_cx <= '0;
                        if (r_cy == clr_h) begin
                            r_state <= S_DONE;
                        end else begin
                            r_cy <= r_cy + 5'd8;
                        end
                    end else begin
                        r_cx <= r_cx + 5'd8;
                    end
                end
                S_SEARCH: begin
                    if (nonempty_cur) begin
                        r_state <= S_READ;
                    end else if (gn == 2'd0) begin
                        r_rsp.status <= tsba_pkg::ST_OOM;
                        r_rsp_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_cur <= cand;
                        if (r_count[cand] == '0 && r_ns < 4'd12) begin
                            r_slice[r_ns] <= cand;
                            r_ns <= r_ns + 4'd1;
                        end
                    end
                end
                S_READ: begin
                    // ram_rdata holds the popped block
                    r_head[r_cur]  <= ring_add(r_head[r_cur], CW'(1));
                    r_count[r_cur] <= r_count[r_cur] - 1'b1;
                    r_bx <= ram_rdata[4:0];
                    r_by <= ram_rdata[9:5];
                    r_w  <= tsba_pkg::shape_lw(r_cur);
                    r_h  <= tsba_pkg::shape_lh(r_cur);
                    r_rsp.block_x     <= ram_rdata[4:0];
                    r_rsp.block_y     <= ram_rdata[9:5];
                    r_rsp.tile_offset <= off;
                    if (r_slice[0] == r_cur) begin
                        r_rsp_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    if (ram_we) begin
                        r_count[tsl] <= r_count[tsl] + 1'b1;
                    end
                    r_w <= nw;
                    r_h <= nh;
                    r_ns <= r_ns - 4'd1;
                    if (r_ns == 4'd1) begin
                        r_rsp_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_DONE: begin
                    r_rsp_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !req.ready)
        else $error("request taken while busy");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && !rsp.ready) |=> (r_rsp_valid && $stable(r_rsp)))
        else $error("response changed while stalled");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[tsba_pkg::BIGGEST] <= CW'(LIST_DEPTH))
        else $error("list count overflow");
endmodule

`default_nettype wire
